FILE: src/mfa_pkg.sv
// Shared constants and types for the mixed fraction arithmetic block.
package mfa_pkg;

   // Fits the overflow check; the port widths stay fixed.
   localparam int WIDTH = 32;

   localparam int FIELD_W   = 32;
   localparam int DEN_W     = 31;
   localparam int HALF_W    = 32;
   localparam int OPND_W    = 2 * HALF_W;
   localparam int ACC_W     = 2 * OPND_W;
   localparam int DIV_CNT_W = $clog2(ACC_W);
   localparam int SHIFT_W   = $clog2(ACC_W);
   localparam int STEP_W    = 3;

   localparam logic [DEN_W-1:0] DEN_ONE  = DEN_W'(1);
   localparam logic [ACC_W-1:0] LIMIT    = ACC_W'(1) << (WIDTH - 1);
   localparam logic [ACC_W-1:0] LIMIT_M1 = LIMIT - ACC_W'(1);

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DIV_ZERO  = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

endpackage

FILE: src/mixed_fraction_arithmetic.sv
// Mixed fraction arithmetic: add, subtract, multiply or divide two mixed numbers.
//
// Each request carries an operation and two mixed numbers (whole, numerator,
// denominator; a zero denominator counts as one). Both operands are turned into
// improper fractions, combined exactly in up to 128 bits of sign and magnitude,
// reduced by their greatest common divisor and returned as a mixed number whose
// whole part is the truncated quotient and whose numerator carries the sign of
// the value, over a positive reduced denominator. Dividing by a zero value
// returns status 1 with 0 0/1; a result whose denominator or whole part does not
// fit WIDTH bits returns status 2 with 0 0/1. One request is worked on at a
// time: req_stall stays high from the transfer until the result is handed to
// the output register. Most of the work is done by three 128-step shift-subtract
// divisions, the binary GCD loop (one subtract or shift a cycle, then shifting
// the common power of two back in) and four or five products on the 64x64
// multiplier. Division by a zero value finishes after the two operand
// conversions. The result register lets the next request transfer while a
// result still waits.
module mixed_fraction_arithmetic (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_operation,
   input  logic signed [31:0]   req_left_whole,
   input  logic signed [31:0]   req_left_numerator,
   input  logic [30:0]          req_left_denominator,
   input  logic signed [31:0]   req_right_whole,
   input  logic signed [31:0]   req_right_numerator,
   input  logic [30:0]          req_right_denominator,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_result_whole,
   output logic signed [31:0]   rsp_result_numerator,
   output logic [30:0]          rsp_result_denominator,
   output logic [1:0]           rsp_status
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_LEFT,    // |left whole| * left denominator
      S_MUL_RIGHT,   // |right whole| * right denominator
      S_MUL_P0,      // first cross product (numerator side)
      S_MUL_P1,      // second cross product, or the denominator
      S_MUL_P2,      // denominator for add and subtract
      S_SUM,         // signed add of the two cross products
      S_GCD_INIT,
      S_GCD,         // binary GCD, one step a cycle
      S_GSHIFT,      // restore the common power of two
      S_DIV_DEN,     // den / g
      S_DIV_NUM,     // num / g
      S_DIV_RES,     // reduced num / reduced den
      S_DONE
   } state_type;

   localparam int FW = mfa_pkg::FIELD_W;
   localparam int DW = mfa_pkg::DEN_W;
   localparam int OW = mfa_pkg::OPND_W;
   localparam int AW = mfa_pkg::ACC_W;

   state_type                     state_ff, state_in;
   mfa_pkg::op_type               op_ff, op_in;
   logic [FW-1:0]                 lw_ff, lw_in;
   logic [FW-1:0]                 ln_ff, ln_in;
   logic [DW-1:0]                 ld_ff, ld_in;
   logic [FW-1:0]                 rw_ff, rw_in;
   logic [FW-1:0]                 rn_ff, rn_in;
   logic [DW-1:0]                 rd_ff, rd_in;

   logic                          a_neg_ff, a_neg_in;
   logic [OW-1:0]                 a_mag_ff, a_mag_in;
   logic                          b_neg_ff, b_neg_in;
   logic [OW-1:0]                 b_mag_ff, b_mag_in;

   logic                          num_neg_ff, num_neg_in;
   logic [AW-1:0]                 num_ff, num_in;
   logic [AW-1:0]                 den_ff, den_in;
   logic [AW-1:0]                 aux_ff, aux_in;
   logic [AW-1:0]                 ga_ff, ga_in;
   logic [AW-1:0]                 gb_ff, gb_in;
   logic [mfa_pkg::SHIFT_W-1:0]   k_ff, k_in;
   logic [AW-1:0]                 dred_ff, dred_in;
   logic [AW-1:0]                 quo_ff, quo_in;
   logic [DW-1:0]                 rem_ff, rem_in;
   mfa_pkg::status_type           status_ff, status_in;

   logic                          mul_go_ff, mul_go_in;
   logic                          div_go_ff, div_go_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]                 rsp_whole_ff, rsp_whole_in;
   logic [FW-1:0]                 rsp_num_ff, rsp_num_in;
   logic [DW-1:0]                 rsp_den_ff, rsp_den_in;
   mfa_pkg::status_type           rsp_status_ff, rsp_status_in;

   // shared unit hookup
   logic [OW-1:0]                 mul_a, mul_b;
   logic                          mul_done;
   logic [AW-1:0]                 mul_prod;
   logic [AW-1:0]                 div_n, div_d;
   logic                          div_done;
   logic [AW-1:0]                 div_q, div_r;

   // improper conversion of the operand in flight
   logic [FW-1:0]                 sel_whole, sel_num;
   logic [DW-1:0]                 sel_den;
   logic [FW-1:0]                 abs_whole;
   logic [OW-1:0]                 signed_prod;
   logic [OW-1:0]                 improper;
   logic                          imp_neg;
   logic [OW-1:0]                 imp_mag;

   // cross product sum
   logic                          y_neg;
   logic                          x_ge_y;
   logic [AW-1:0]                 sum_mag;
   logic                          sum_neg;

   // gcd step
   logic [AW:0]                   ga_minus_gb;
   logic [AW-1:0]                 gb_minus_ga;

   // final formatting
   logic                          out_free;
   logic                          overflow;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------------
   // Operand conversion: whole * den + num, for either sign.
   // ---------------------------------------------------------------------------
   assign sel_whole   = (state_ff == S_MUL_LEFT) ? lw_ff : rw_ff;
   assign sel_num     = (state_ff == S_MUL_LEFT) ? ln_ff : rn_ff;
   assign sel_den     = (state_ff == S_MUL_LEFT) ? ld_ff : rd_ff;
   assign abs_whole   = sel_whole[FW-1] ? (FW'(0) - sel_whole) : sel_whole;
   assign signed_prod = sel_whole[FW-1] ? (OW'(0) - mul_prod[OW-1:0]) : mul_prod[OW-1:0];
   assign improper    = signed_prod + {{(OW-FW){sel_num[FW-1]}}, sel_num};
   assign imp_neg     = improper[OW-1];
   assign imp_mag     = imp_neg ? (OW'(0) - improper) : improper;

   // ---------------------------------------------------------------------------
   // Multiplier operands follow the state that started it.
   // ---------------------------------------------------------------------------
   always_comb begin
      mul_a = {(OW-FW)'(0), abs_whole};
      mul_b = {(OW-DW)'(0), sel_den};
      unique case (state_ff)
         S_MUL_P0: begin
            mul_a = a_mag_ff;
            mul_b = (op_ff == mfa_pkg::OP_MUL) ? b_mag_ff : {(OW-DW)'(0), rd_ff};
         end
         S_MUL_P1: begin
            unique case (op_ff)
               mfa_pkg::OP_ADD, mfa_pkg::OP_SUB: begin
                  mul_a = b_mag_ff;
                  mul_b = {(OW-DW)'(0), ld_ff};
               end
               mfa_pkg::OP_MUL: begin
                  mul_a = {(OW-DW)'(0), ld_ff};
                  mul_b = {(OW-DW)'(0), rd_ff};
               end
               mfa_pkg::OP_DIV: begin
                  mul_a = {(OW-DW)'(0), ld_ff};
                  mul_b = b_mag_ff;
               end
            endcase
         end
         S_MUL_P2: begin
            mul_a = {(OW-DW)'(0), ld_ff};
            mul_b = {(OW-DW)'(0), rd_ff};
         end
         default: begin
         end
      endcase
   end

   // Divider operands.
   always_comb begin
      div_n = den_ff;
      div_d = ga_ff;
      unique case (state_ff)
         S_DIV_NUM: begin
            div_n = num_ff;
            div_d = ga_ff;
         end
         S_DIV_RES: begin
            div_n = num_ff;
            div_d = dred_ff;
         end
         default: begin
         end
      endcase
   end

   mfa_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_go_ff),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   mfa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go_ff),
      .dividend  (div_n),
      .divisor   (div_d),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // ---------------------------------------------------------------------------
   // Signed add of the cross products (num_ff holds x, aux_ff holds y).
   // ---------------------------------------------------------------------------
   assign y_neg  = ((op_ff == mfa_pkg::OP_SUB) ? !b_neg_ff : b_neg_ff) && (aux_ff != '0);
   assign x_ge_y = num_ff >= aux_ff;

   always_comb begin
      if (a_neg_ff == y_neg) begin
         sum_mag = num_ff + aux_ff;
         sum_neg = a_neg_ff;
      end else if (x_ge_y) begin
         sum_mag = num_ff - aux_ff;
         sum_neg = a_neg_ff;
      end else begin
         sum_mag = aux_ff - num_ff;
         sum_neg = y_neg;
      end
   end

   assign ga_minus_gb = {1'b0, ga_ff} - {1'b0, gb_ff};
   assign gb_minus_ga = gb_ff - ga_ff;

   // Reduced result must fit: den below 2^(WIDTH-1), whole within signed range.
   assign overflow = (dred_ff > mfa_pkg::LIMIT_M1) ||
                     (quo_ff > (num_neg_ff ? mfa_pkg::LIMIT : mfa_pkg::LIMIT_M1));

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      lw_in         = lw_ff;
      ln_in         = ln_ff;
      ld_in         = ld_ff;
      rw_in         = rw_ff;
      rn_in         = rn_ff;
      rd_in         = rd_ff;
      a_neg_in      = a_neg_ff;
      a_mag_in      = a_mag_ff;
      b_neg_in      = b_neg_ff;
      b_mag_in      = b_mag_ff;
      num_neg_in    = num_neg_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      aux_in        = aux_ff;
      ga_in         = ga_ff;
      gb_in         = gb_ff;
      k_in          = k_ff;
      dred_in       = dred_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      status_in     = status_ff;
      mul_go_in     = 1'b0;
      div_go_in     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_whole_in  = rsp_whole_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_den_in    = rsp_den_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = mfa_pkg::op_type'(req_operation);
               lw_in     = req_left_whole;
               ln_in     = req_left_numerator;
               ld_in     = (req_left_denominator == '0) ? mfa_pkg::DEN_ONE
                                                        : req_left_denominator;
               rw_in     = req_right_whole;
               rn_in     = req_right_numerator;
               rd_in     = (req_right_denominator == '0) ? mfa_pkg::DEN_ONE
                                                         : req_right_denominator;
               status_in = mfa_pkg::ST_OK;
               num_neg_in = 1'b0;
               mul_go_in = 1'b1;
               state_in  = S_MUL_LEFT;
            end
         end

         S_MUL_LEFT: begin
            if (mul_done) begin
               a_neg_in  = imp_neg;
               a_mag_in  = imp_mag;
               mul_go_in = 1'b1;
               state_in  = S_MUL_RIGHT;
            end
         end

         S_MUL_RIGHT: begin
            if (mul_done) begin
               b_neg_in = imp_neg;
               b_mag_in = imp_mag;
               if (op_ff == mfa_pkg::OP_DIV && imp_mag == '0) begin
                  // dividing by a zero value: report and skip the rest
                  status_in = mfa_pkg::ST_DIV_ZERO;
                  state_in  = S_DONE;
               end else begin
                  mul_go_in = 1'b1;
                  state_in  = S_MUL_P0;
               end
            end
         end

         S_MUL_P0: begin
            if (mul_done) begin
               num_in     = mul_prod;
               num_neg_in = (mul_prod != '0) && (a_neg_ff != b_neg_ff);
               mul_go_in  = 1'b1;
               state_in   = S_MUL_P1;
            end
         end

         S_MUL_P1: begin
            if (mul_done) begin
               if (op_ff == mfa_pkg::OP_ADD || op_ff == mfa_pkg::OP_SUB) begin
                  aux_in    = mul_prod;
                  mul_go_in = 1'b1;
                  state_in  = S_MUL_P2;
               end else begin
                  den_in   = mul_prod;
                  state_in = S_GCD_INIT;
               end
            end
         end

         S_MUL_P2: begin
            if (mul_done) begin
               den_in   = mul_prod;
               state_in = S_SUM;
            end
         end

         S_SUM: begin
            num_in     = sum_mag;
            num_neg_in = sum_neg && (sum_mag != '0);
            state_in   = S_GCD_INIT;
         end

         S_GCD_INIT: begin
            ga_in    = num_ff;
            gb_in    = den_ff;
            k_in     = '0;
            state_in = S_GCD;
         end

         S_GCD: begin
            // gcd ends up in ga_ff, still missing the common factor 2^k
            priority if (ga_ff == '0) begin
               ga_in    = gb_ff;
               state_in = S_GSHIFT;
            end else if (gb_ff == '0) begin
               state_in = S_GSHIFT;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               k_in  = k_ff + mfa_pkg::SHIFT_W'(1);
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (!ga_minus_gb[AW]) begin
               ga_in = ga_minus_gb[AW-1:0] >> 1;
            end else begin
               gb_in = gb_minus_ga >> 1;
            end
         end

         S_GSHIFT: begin
            if (k_ff == '0) begin
               div_go_in = 1'b1;
               state_in  = S_DIV_DEN;
            end else begin
               ga_in = ga_ff << 1;
               k_in  = k_ff - mfa_pkg::SHIFT_W'(1);
            end
         end

         S_DIV_DEN: begin
            if (div_done) begin
               dred_in   = div_q;
               div_go_in = 1'b1;
               state_in  = S_DIV_NUM;
            end
         end

         S_DIV_NUM: begin
            if (div_done) begin
               num_in    = div_q;
               div_go_in = 1'b1;
               state_in  = S_DIV_RES;
            end
         end

         S_DIV_RES: begin
            if (div_done) begin
               quo_in   = div_q;
               rem_in   = div_r[DW-1:0];
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (status_ff == mfa_pkg::ST_DIV_ZERO || overflow) begin
                  rsp_whole_in  = '0;
                  rsp_num_in    = '0;
                  rsp_den_in    = mfa_pkg::DEN_ONE;
                  rsp_status_in = (status_ff == mfa_pkg::ST_DIV_ZERO) ?
                                  mfa_pkg::ST_DIV_ZERO : mfa_pkg::ST_OVERFLOW;
               end else begin
                  rsp_whole_in  = num_neg_ff ? (FW'(0) - quo_ff[FW-1:0]) : quo_ff[FW-1:0];
                  rsp_num_in    = num_neg_ff ? (FW'(0) - {1'b0, rem_ff}) : {1'b0, rem_ff};
                  rsp_den_in    = dred_ff[DW-1:0];
                  rsp_status_in = mfa_pkg::ST_OK;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      lw_ff         <= lw_in;
      ln_ff         <= ln_in;
      ld_ff         <= ld_in;
      rw_ff         <= rw_in;
      rn_ff         <= rn_in;
      rd_ff         <= rd_in;
      a_neg_ff      <= a_neg_in;
      a_mag_ff      <= a_mag_in;
      b_neg_ff      <= b_neg_in;
      b_mag_ff      <= b_mag_in;
      num_neg_ff    <= num_neg_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      aux_ff        <= aux_in;
      ga_ff         <= ga_in;
      gb_ff         <= gb_in;
      k_ff          <= k_in;
      dred_ff       <= dred_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      status_ff     <= status_in;
      rsp_whole_ff  <= rsp_whole_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_den_ff    <= rsp_den_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_go_ff    <= mul_go_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall              = reset || (state_ff != S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_whole       = rsp_whole_ff;
   assign rsp_result_numerator   = rsp_num_ff;
   assign rsp_result_denominator = rsp_den_ff;
   assign rsp_status             = rsp_status_ff;

endmodule

FILE: src/mfa_mul.sv
// Sequential 64x64 multiplier built on one 32x32 partial product per cycle.
module mfa_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mfa_pkg::OPND_W-1:0]  a,
   input  logic [mfa_pkg::OPND_W-1:0]  b,
   output logic                        done,
   output logic [mfa_pkg::ACC_W-1:0]   product
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [mfa_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [mfa_pkg::OPND_W-1:0]    a_ff, a_in;
   logic [mfa_pkg::OPND_W-1:0]    b_ff, b_in;
   logic [mfa_pkg::OPND_W-1:0]    prod_ff, prod_in;
   logic [1:0]                    pshift_ff, pshift_in;
   logic [mfa_pkg::ACC_W-1:0]     acc_ff, acc_in;

   logic [mfa_pkg::HALF_W-1:0]    a_slice;
   logic [mfa_pkg::HALF_W-1:0]    b_slice;
   logic [mfa_pkg::ACC_W-1:0]     prod_aligned;

   // step[1] picks the half of a, step[0] the half of b
   assign a_slice = step_ff[1] ? a_ff[mfa_pkg::OPND_W-1:mfa_pkg::HALF_W]
                               : a_ff[mfa_pkg::HALF_W-1:0];
   assign b_slice = step_ff[0] ? b_ff[mfa_pkg::OPND_W-1:mfa_pkg::HALF_W]
                               : b_ff[mfa_pkg::HALF_W-1:0];

   always_comb begin
      case (pshift_ff)
         2'd1:    prod_aligned = mfa_pkg::ACC_W'(prod_ff) << mfa_pkg::HALF_W;
         2'd2:    prod_aligned = mfa_pkg::ACC_W'(prod_ff) << mfa_pkg::OPND_W;
         default: prod_aligned = mfa_pkg::ACC_W'(prod_ff);
      endcase
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      prod_in   = prod_ff;
      pshift_in = pshift_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (step_ff != mfa_pkg::STEP_W'(4)) begin
            prod_in   = mfa_pkg::OPND_W'(a_slice) * mfa_pkg::OPND_W'(b_slice);
            pshift_in = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
         end
         if (step_ff != '0) begin
            acc_in = acc_ff + prod_aligned;
         end
         if (step_ff == mfa_pkg::STEP_W'(4)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         step_in = step_ff + mfa_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      prod_ff   <= prod_in;
      pshift_ff <= pshift_in;
      acc_ff    <= acc_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

FILE: src/mfa_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
module mfa_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [mfa_pkg::ACC_W-1:0]  dividend,
   input  logic [mfa_pkg::ACC_W-1:0]  divisor,
   output logic                       done,
   output logic [mfa_pkg::ACC_W-1:0]  quotient,
   output logic [mfa_pkg::ACC_W-1:0]  remainder
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [mfa_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [mfa_pkg::ACC_W-1:0]       quo_ff, quo_in;
   logic [mfa_pkg::ACC_W-1:0]       rem_ff, rem_in;
   logic [mfa_pkg::ACC_W-1:0]       dsr_ff, dsr_in;

   logic [mfa_pkg::ACC_W:0]         shifted;
   logic [mfa_pkg::ACC_W:0]         trial;
   logic                            fits;

   assign shifted = {rem_ff, quo_ff[mfa_pkg::ACC_W-1]};
   assign trial   = shifted - {1'b0, dsr_ff};
   assign fits    = shifted >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[mfa_pkg::ACC_W-2:0], fits};
         rem_in = fits ? trial[mfa_pkg::ACC_W-1:0] : shifted[mfa_pkg::ACC_W-1:0];
         cnt_in = cnt_ff + mfa_pkg::DIV_CNT_W'(1);
         if (cnt_ff == mfa_pkg::DIV_CNT_W'(mfa_pkg::ACC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: src/mfa_checker.sv
// Port-level checks for the mixed fraction arithmetic block, bound to the top level.
module mfa_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic signed [31:0]   rsp_result_whole,
   input  logic signed [31:0]   rsp_result_numerator,
   input  logic [30:0]          rsp_result_denominator,
   input  logic [1:0]           rsp_status
);

   // a held result stays put until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_whole) &&
                                 $stable(rsp_result_numerator) &&
                                 $stable(rsp_result_denominator) && $stable(rsp_status))
      else $error("result changed while stalled");

   // one request at a time: busy right after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_denominator != 31'd0)
      else $error("zero denominator in result");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mfa_pkg::ST_OK |->
         rsp_result_whole == 32'sd0 && rsp_result_numerator == 32'sd0 &&
         rsp_result_denominator == 31'd1)
      else $error("error result not 0 0/1");

   // truncating split: whole and remainder never disagree in sign
   a_sign_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_whole != 32'sd0 && rsp_result_numerator != 32'sd0 |->
         rsp_result_whole[31] == rsp_result_numerator[31])
      else $error("whole and numerator signs differ");

endmodule

bind mixed_fraction_arithmetic mfa_checker u_mfa_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_result_whole       (rsp_result_whole),
   .rsp_result_numerator   (rsp_result_numerator),
   .rsp_result_denominator (rsp_result_denominator),
   .rsp_status             (rsp_status)
);
